@@ hw/rtl/byte_frequency_sorter_assert.svh @@
// Assertion macros for the byte frequency sorter RTL.
`ifndef BYTE_FREQUENCY_SORTER_ASSERT_SVH
`define BYTE_FREQUENCY_SORTER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define BFS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define BFS_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ hw/rtl/bfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bfs_pkg
// Types and constants of the byte frequency sorter.
// ----------------------------------------------------------------------------
`default_nettype none
package bfs_pkg;
	localparam int unsigned COUNT_BITS_DEF = 32;
	localparam int unsigned NUM_SYMS = 256;
	localparam int unsigned SYM_BITS = 8;
	localparam int unsigned IDX_BITS = 9;

	localparam logic FUNC_COUNT = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	typedef struct packed {
		logic                func;
		logic [SYM_BITS-1:0] symbol;
	} in_item_t;

	typedef struct packed {
		logic [SYM_BITS-1:0]       symbol_res;
		logic [COUNT_BITS_DEF-1:0] count;
		logic                      last;
		logic                      empty_res;
	} out_item_t;

	// Control from the sequencer to every sorting cell
	typedef struct packed {
		logic clear;   // empty all cells
		logic ins;     // insert the element on the chain input
		logic shift;   // shift the row toward the head by one
	} cell_ctl_t;
endpackage
`default_nettype wire

@@ hw/rtl/bfs_ram.sv @@
// ----------------------------------------------------------------------------
// bfs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bfs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read one word a cycle, and write it too when we is set
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

@@ hw/rtl/bfs_cell.sv @@
// ----------------------------------------------------------------------------
// bfs_cell
// One cell of the insertion sorting chain: holds one (count, symbol) pair.
// ----------------------------------------------------------------------------
`default_nettype none
module bfs_cell #(
	parameter int unsigned COUNT_BITS = bfs_pkg::COUNT_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire bfs_pkg::cell_ctl_t          ctl,
	input  wire logic [COUNT_BITS-1:0]       new_cnt,
	input  wire logic [bfs_pkg::SYM_BITS-1:0] new_sym,
	// neighbor toward the head (lower position)
	input  wire logic                        prev_vld,
	input  wire logic                        prev_push,
	input  wire logic [COUNT_BITS-1:0]       prev_cnt,
	input  wire logic [bfs_pkg::SYM_BITS-1:0] prev_sym,
	// neighbor toward the tail, for shifting out
	input  wire logic                        next_vld,
	input  wire logic [COUNT_BITS-1:0]       next_cnt,
	input  wire logic [bfs_pkg::SYM_BITS-1:0] next_sym,
	output logic                             vld,
	output logic                             push,
	output logic [COUNT_BITS-1:0]            cnt,
	output logic [bfs_pkg::SYM_BITS-1:0]     sym
);
	import bfs_pkg::*;

	logic                vld_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic [SYM_BITS-1:0] sym_q;

	// Newcomer goes ahead of any element with a strictly larger count
	assign push = vld_q && (cnt_q > new_cnt);
	assign vld  = vld_q;
	assign cnt  = cnt_q;
	assign sym  = sym_q;

	// Clear, hold, take the newcomer, take the left neighbor, or shift to head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clear) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= next_vld;
		end else if (ctl.ins) begin
			// an empty cell fills when its left neighbor is occupied
			vld_q <= vld_q || prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			cnt_q <= next_cnt;
			sym_q <= next_sym;
		end else if (ctl.ins) begin
			if (prev_push) begin
				cnt_q <= prev_cnt;
				sym_q <= prev_sym;
			end else if (push || (!vld_q && prev_vld)) begin
				cnt_q <= new_cnt;
				sym_q <= new_sym;
			end
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/byte_frequency_sorter.sv @@
// ----------------------------------------------------------------------------
// byte_frequency_sorter
// Byte histogram with an insertion-sorting cell chain for rising-count reads.
// ----------------------------------------------------------------------------
// Channel | Handshake        | Payload
// input   | start && !busy   | item_in  (func, symbol)
// result  | strobe           | item_out (symbol_res, count, last, empty_res)
//
// A count transaction reads the histogram RAM entry, then writes it back.
// A read with nothing counted strobes the empty marker in the next cycle.
// The first read after counting sweeps all 256 histogram entries through the
// RAM port into the cell chain, then strobes the head cell. Later reads strobe
// the head cell directly and shift the chain toward the head. The final read
// adds a clearing sweep over all 256 histogram entries, and reset is followed
// by the same clearing pass before busy drops.
// Results appear for one cycle with strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none
module byte_frequency_sorter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire bfs_pkg::in_item_t  item_in,
	output logic                    strobe,
	output bfs_pkg::out_item_t      item_out
);
	import bfs_pkg::*;

	localparam int unsigned COUNT_BITS = COUNT_BITS_DEF;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_CNT   = 3'd2;
	localparam logic [2:0] ST_SORT  = 3'd3;
	localparam logic [2:0] ST_LOAD  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]          state_q;
	logic [SYM_BITS-1:0] sym_q;
	logic [IDX_BITS-1:0] ptr_q;      // sweep address, one past the range at end
	logic [IDX_BITS-1:0] distinct_q;
	logic [IDX_BITS-1:0] left_q;     // entries not yet read in the pass
	logic                sorted_q;
	logic                ins_q;      // RAM data of the previous sweep address due

	logic                   ram_we;
	logic [SYM_BITS-1:0]    ram_addr;
	logic [COUNT_BITS-1:0]  ram_wdata;
	logic [COUNT_BITS-1:0]  ram_rdata;
	logic [SYM_BITS-1:0]    ins_sym_q;

	cell_ctl_t              ctl;
	logic [NUM_SYMS:0]      c_vld;
	logic [NUM_SYMS-1:0]    c_push;
	logic [COUNT_BITS-1:0]  c_cnt [NUM_SYMS+1];
	logic [SYM_BITS-1:0]    c_sym [NUM_SYMS+1];
	logic                   is_last;

	bfs_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_SYMS)) u_hist (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Tail end of the chain reads as empty
	assign c_vld[NUM_SYMS]  = 1'b0;
	assign c_cnt[NUM_SYMS]  = '0;
	assign c_sym[NUM_SYMS]  = '0;

	genvar g;
	generate
		for (g = 0; g < NUM_SYMS; g++) begin : g_cell
			logic pv, pp;
			logic [COUNT_BITS-1:0] pc;
			logic [SYM_BITS-1:0] ps;
			if (g == 0) begin : g_head
				assign pv = 1'b1;
				assign pp = 1'b0;
				assign pc = '0;
				assign ps = '0;
			end else begin : g_body
				assign pv = c_vld[g-1];
				assign pp = c_push[g-1];
				assign pc = c_cnt[g-1];
				assign ps = c_sym[g-1];
			end
			bfs_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl),
				.new_cnt(ram_rdata), .new_sym(ins_sym_q),
				.prev_vld(pv), .prev_push(pp), .prev_cnt(pc), .prev_sym(ps),
				.next_vld(c_vld[g+1]), .next_cnt(c_cnt[g+1]), .next_sym(c_sym[g+1]),
				.vld(c_vld[g]), .push(c_push[g]), .cnt(c_cnt[g]), .sym(c_sym[g])
			);
		end
	endgenerate

	assign busy    = (state_q != ST_IDLE);
	assign is_last = (left_q == IDX_BITS'(1));

	// Drive the histogram port and cell controls
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = sym_q;
		ram_wdata = ram_rdata;
		ctl       = '0;
		case (state_q)
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_addr  = ptr_q[SYM_BITS-1:0];
				ram_wdata = '0;
			end
			ST_IDLE: begin
				ram_addr = item_in.symbol;
			end
			ST_CNT: begin
				ram_we    = 1'b1;
				ram_wdata = (ram_rdata == {COUNT_BITS{1'b1}}) ? ram_rdata
				            : ram_rdata + COUNT_BITS'(1);
			end
			ST_SORT: begin
				ram_addr  = ptr_q[SYM_BITS-1:0];
				ctl.clear = (ptr_q == '0) && !ins_q;
				ctl.ins   = ins_q && (ram_rdata != '0);
			end
			ST_OUT: begin
				ctl.shift = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequence transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			ptr_q      <= '0;
			distinct_q <= '0;
			left_q     <= '0;
			sorted_q   <= 1'b0;
			ins_q      <= 1'b0;
			strobe     <= 1'b0;
		end else begin
			strobe <= 1'b0;
			case (state_q)
				ST_CLR: begin
					ptr_q <= ptr_q + IDX_BITS'(1);
					if (ptr_q == IDX_BITS'(NUM_SYMS - 1)) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						if (item_in.func == FUNC_COUNT) begin
							state_q <= ST_CNT;
						end else if (distinct_q == '0) begin
							strobe <= 1'b1;
						end else if (!sorted_q) begin
							ptr_q   <= '0;
							ins_q   <= 1'b0;
							state_q <= ST_SORT;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_CNT: begin
					if (ram_rdata == '0) begin
						distinct_q <= distinct_q + IDX_BITS'(1);
					end
					sorted_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				ST_SORT: begin
					ins_q <= !ptr_q[SYM_BITS];
					if (!ptr_q[SYM_BITS]) begin
						ptr_q <= ptr_q + IDX_BITS'(1);
					end
					if (ptr_q[SYM_BITS] && ins_q) begin
						sorted_q <= 1'b1;
						left_q   <= distinct_q;
						ins_q    <= 1'b0;
						state_q  <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					strobe  <= 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					left_q <= left_q - IDX_BITS'(1);
					if (is_last) begin
						distinct_q <= '0;
						sorted_q   <= 1'b0;
						ptr_q      <= '0;
						state_q    <= ST_CLR;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture symbol of the transaction and of the entry fed to the chain
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			sym_q <= item_in.symbol;
		end
		ins_sym_q <= ptr_q[SYM_BITS-1:0];
	end

	// Result register: head cell, or the empty marker
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			item_out.symbol_res <= c_sym[0];
			item_out.count      <= c_cnt[0];
			item_out.last       <= is_last;
			item_out.empty_res  <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			item_out.symbol_res <= '0;
			item_out.count      <= '0;
			item_out.last       <= 1'b0;
			item_out.empty_res  <= 1'b1;
		end
	end

`include "byte_frequency_sorter_assert.svh"
	`BFS_ASSERT(a_no_start_result, !(strobe && $past(state_q) == ST_CNT), "count gave result")
	`BFS_ASSERT_NEXT(a_last_clears, strobe && item_out.last, distinct_q == '0, "not cleared")
	`BFS_ASSERT(a_head_valid, !(state_q == ST_LOAD && !c_vld[0]), "empty head on read")
endmodule
`default_nettype wire
